// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during rst.
`define LPHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, held off during rst.
`define LPHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/lpht_pkg.sv =====
`timescale 1ns / 1ps
package lpht_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int HASH_BITS      = 32;
  localparam int SLOT_BITS      = 9;
  localparam int COUNT_BITS     = 8;

  localparam logic [7:0] FILL_LIMIT_RST = 8'd192;
  localparam logic [2:0] REG_FILL_LIMIT = 3'd0;

  // Commands
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_LOOKUP = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_NEXT   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [SLOT_BITS-1:0] SLOT_NONE = '1;

endpackage

// ===== design/linear_probe_hash_table_core.sv =====
`timescale 1ns / 1ps
// Open-addressing hash table with linear probing and backward-shift removal.
// One transaction in, one result out. The table entries (stored hash, key,
// value) live in a single memory with one write and one registered read port;
// occupancy marks are flip-flops and are cleared by reset and by the clear
// command. Add, lookup and remove probe from the home bucket until a match or
// an empty slot; remove then shifts back the entries of the cluster that
// follows the removed entry, up to the empty slot that ends the cluster;
// next-slot iteration tests slots in order and reads the entry found. Every
// transaction then hands its result to the output, waiting while the previous
// result is still stalled there. A refused add, clear, an unused command and
// an iteration that starts past the last slot go straight to the result.
// CAPACITY must be a power of two: the home bucket is the low bits of
// hash_in + 1. Input is stalled while a transaction is in work.
module linear_probe_hash_table_core #(
  parameter int CAPACITY   = lpht_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [31:0] key,
  input  logic [31:0] hash_in,
  input  logic [31:0] value_in,
  input  logic signed [8:0] slot_in,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] value_out,
  output logic [31:0] key_out,
  output logic signed [8:0] slot_out,
  output logic [7:0]  entry_count,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpht_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int EW = HASH_BITS + KEY_BITS + VALUE_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_PROBE, S_PCHK, S_RISSUE, S_RCHK, S_SCAN, S_SRD, S_DONE
  } state_t;

  state_t                  state;
  logic [CAPACITY-1:0]     valid_marks;
  logic [COUNT_BITS-1:0]   count;
  logic [7:0]              fill_limit;
  logic [2:0]              cmd_r;
  logic [HASH_BITS-1:0]    h_r;
  logic [KEY_BITS-1:0]     k_r;
  logic [VALUE_BITS-1:0]   v_r;
  logic [IW-1:0]           s;
  logic [IW-1:0]           gap;
  logic [IW-1:0]           j;
  logic [1:0]              res_status;
  logic [31:0]             res_value;
  logic [31:0]             res_key;
  logic [SLOT_BITS-1:0]    res_slot;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [EW-1:0]           ram_wdata;
  logic [IW-1:0]           ram_raddr;
  logic [EW-1:0]           ram_rdata;

  logic [HASH_BITS-1:0]    h_in;
  logic [HASH_BITS-1:0]    rd_hash;
  logic [KEY_BITS-1:0]     rd_key;
  logic [VALUE_BITS-1:0]   rd_val;
  logic [IW-1:0]           j_next;
  logic [IW-1:0]           home;
  logic                    in_range;
  logic                    match;
  logic                    at_limit;
  logic                    cfg_wr;
  int                      lim;
  int                      start;

  // Table memory
  lpht_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Unpack entry and derive probe helpers
  always_comb begin
    h_in     = hash_in + HASH_BITS'(1);
    rd_hash  = ram_rdata[EW-1 -: HASH_BITS];
    rd_key   = ram_rdata[VALUE_BITS +: KEY_BITS];
    rd_val   = ram_rdata[VALUE_BITS-1:0];
    match    = (rd_hash == h_r) && (rd_key == k_r);
    j_next   = j + IW'(1);
    home     = rd_hash[IW-1:0];
    // home within the circular range (gap, j]
    if (gap <= j) begin
      in_range = (gap < home) && (home <= j);
    end else begin
      in_range = (home > gap) || (home <= j);
    end
    lim      = (int'(fill_limit) > CAPACITY - 1) ? CAPACITY - 1 : int'(fill_limit);
    at_limit = int'(count) >= lim;
    start    = slot_in[8] ? 0 : int'(slot_in) + 1;
  end

  // Memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s;
    ram_wdata = {h_r, k_r, v_r};
    ram_raddr = s;
    unique case (state)
      S_PROBE: begin
        ram_we = (cmd_r == CMD_ADD) && !valid_marks[s];
      end
      S_RISSUE: begin
        ram_raddr = j_next;
      end
      S_RCHK: begin
        ram_we    = !in_range;
        ram_waddr = gap;
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  // Configuration port
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_FILL_LIMIT) ? 32'(fill_limit) : 32'd0;
  assign in_stall = (state != S_IDLE);

  // Sequencer, table marks and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid_marks <= '0;
      count       <= '0;
      fill_limit  <= FILL_LIMIT_RST;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr && paddr == REG_FILL_LIMIT) begin
        fill_limit <= pwdata[7:0];
      end
      // drop the result once taken
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r      <= cmd;
            h_r        <= h_in;
            k_r        <= KEY_BITS'(key);
            v_r        <= VALUE_BITS'(value_in);
            s          <= h_in[IW-1:0];
            res_status <= ST_NONE;
            res_value  <= '0;
            res_key    <= '0;
            res_slot   <= SLOT_NONE;
            state      <= S_DONE;
            case (cmd)
              CMD_ADD: begin
                if (at_limit) begin
                  res_status <= ST_FULL;
                end else begin
                  state <= S_PROBE;
                end
              end
              CMD_LOOKUP, CMD_REMOVE: begin
                state <= S_PROBE;
              end
              CMD_NEXT: begin
                if (start < CAPACITY) begin
                  s     <= IW'(start);
                  state <= S_SCAN;
                end
              end
              CMD_CLEAR: begin
                valid_marks <= '0;
                count       <= '0;
                res_status  <= ST_OK;
              end
              default: begin
              end
            endcase
          end
        end
        S_PROBE: begin
          if (valid_marks[s]) begin
            state <= S_PCHK;
          end else begin
            // empty slot ends the probe: insert for add
            if (cmd_r == CMD_ADD) begin
              valid_marks[s] <= 1'b1;
              count          <= count + COUNT_BITS'(1);
              res_status     <= ST_OK;
              res_slot       <= SLOT_BITS'(s);
            end
            state <= S_DONE;
          end
        end
        S_PCHK: begin
          if (match) begin
            res_slot <= SLOT_BITS'(s);
            state    <= S_DONE;
            case (cmd_r)
              CMD_ADD: begin
                res_status <= ST_DUP;
              end
              CMD_LOOKUP: begin
                res_status <= ST_OK;
                res_value  <= 32'(rd_val);
                res_key    <= 32'(rd_key);
              end
              default: begin
                res_status     <= ST_OK;
                valid_marks[s] <= 1'b0;
                gap            <= s;
                j              <= s;
                state          <= S_RISSUE;
              end
            endcase
          end else begin
            s     <= s + IW'(1);
            state <= S_PROBE;
          end
        end
        S_RISSUE: begin
          if (valid_marks[j_next]) begin
            j     <= j_next;
            state <= S_RCHK;
          end else begin
            if (count != '0) begin
              count <= count - COUNT_BITS'(1);
            end
            state <= S_DONE;
          end
        end
        S_RCHK: begin
          // shift the entry back into the gap when its home is outside (gap, j]
          if (!in_range) begin
            valid_marks[gap] <= 1'b1;
            valid_marks[j]   <= 1'b0;
            gap              <= j;
          end
          state <= S_RISSUE;
        end
        S_SCAN: begin
          if (valid_marks[s]) begin
            state <= S_SRD;
          end else if (int'(s) == CAPACITY - 1) begin
            state <= S_DONE;
          end else begin
            s <= s + IW'(1);
          end
        end
        S_SRD: begin
          res_status <= ST_OK;
          res_value  <= 32'(rd_val);
          res_key    <= 32'(rd_key);
          res_slot   <= SLOT_BITS'(s);
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            value_out   <= res_value;
            key_out     <= res_key;
            slot_out    <= res_slot;
            entry_count <= count;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/lpht_ram.sv =====
`timescale 1ns / 1ps
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lpht_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lpht_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        status,
  input logic signed [8:0] slot_out
);
  import lpht_pkg::*;

  // one transaction in work at a time
  `LPHT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // a stalled result stays
  `LPHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // refused add names no slot
  `LPHT_ASSERT_NOW(a_full_no_slot, out_valid && status == ST_FULL, slot_out == SLOT_NONE)
  // duplicate and not-found carry consistent slots
  `LPHT_ASSERT_NOW(a_dup_slot, out_valid && status == ST_DUP, !slot_out[8])
  `LPHT_ASSERT_NOW(a_none_slot, out_valid && status == ST_NONE, slot_out == SLOT_NONE)

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .slot_out  (slot_out)
);
